/* src/fsa_pkg.sv */
package fsa_pkg;

	// Width of the checked intermediate range: products and sums above it overflow
	localparam int LIMIT_BITS = 64;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
	localparam logic [1:0] STAT_OVF      = 2'd2;

	// Datapath unit operations
	localparam logic [2:0] OP_GCD  = 3'd0;
	localparam logic [2:0] OP_DIV  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_COPY = 3'd3;
	localparam logic [2:0] OP_ADD  = 3'd4;

	// Datapath register codes
	localparam logic [3:0] R_NONE = 4'd0;
	localparam logic [3:0] R_NM   = 4'd1;
	localparam logic [3:0] R_DM   = 4'd2;
	localparam logic [3:0] R_AM   = 4'd3;
	localparam logic [3:0] R_AD   = 4'd4;
	localparam logic [3:0] R_AR   = 4'd5;
	localparam logic [3:0] R_DR   = 4'd6;
	localparam logic [3:0] R_RM   = 4'd7;
	localparam logic [3:0] R_RD   = 4'd8;
	localparam logic [3:0] R_G    = 4'd9;
	localparam logic [3:0] R_T2   = 4'd10;

	// Sequencer steps
	localparam logic [3:0] STEP_FIRST    = 4'd0;
	localparam logic [3:0] STEP_IN_DONE  = 4'd2;
	localparam logic [3:0] STEP_LAST_ADD = 4'd12;
	localparam logic [3:0] STEP_COPY     = 4'd13;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] src_a;
		logic [3:0] src_b;
		logic [3:0] dst;
	} uop_t;

	typedef struct packed {
		logic load;
		logic start;
		uop_t uop;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero_den;
		logic start_new;
	} sts_t;

	function automatic uop_t ucode(input logic [3:0] step);
		uop_t u;
		case (step)
			4'd0:    u = '{OP_GCD,  R_NM, R_DM, R_G};
			4'd1:    u = '{OP_DIV,  R_NM, R_G,  R_NM};
			4'd2:    u = '{OP_DIV,  R_DM, R_G,  R_DM};
			4'd3:    u = '{OP_GCD,  R_AD, R_DM, R_G};
			4'd4:    u = '{OP_DIV,  R_AD, R_G,  R_AR};
			4'd5:    u = '{OP_DIV,  R_DM, R_G,  R_DR};
			4'd6:    u = '{OP_MUL,  R_AM, R_DR, R_RM};
			4'd7:    u = '{OP_MUL,  R_AR, R_NM, R_T2};
			4'd8:    u = '{OP_MUL,  R_AR, R_DM, R_RD};
			4'd9:    u = '{OP_ADD,  R_NONE, R_NONE, R_NONE};
			4'd10:   u = '{OP_GCD,  R_RM, R_RD, R_G};
			4'd11:   u = '{OP_DIV,  R_RM, R_G,  R_RM};
			4'd12:   u = '{OP_DIV,  R_RD, R_G,  R_RD};
			4'd13:   u = '{OP_COPY, R_NONE, R_NONE, R_NONE};
			default: u = '{OP_COPY, R_NONE, R_NONE, R_NONE};
		endcase
		return u;
	endfunction

endpackage

/* src/fsa_datapath.sv */
module fsa_datapath #(
	parameter int IN_WIDTH  = 16,
	parameter int SUM_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fsa_pkg::cmd_t            cmd,
	output fsa_pkg::sts_t            sts,
	input  logic [IN_WIDTH-1:0]      in_num,
	input  logic [IN_WIDTH-1:0]      in_den,
	input  logic                     in_start,
	output logic [SUM_WIDTH-1:0]     out_num,
	output logic [SUM_WIDTH-2:0]     out_den,
	output logic [1:0]               out_status
);
	localparam int PW = SUM_WIDTH + IN_WIDTH;
	localparam int CW = $clog2(PW + 1);
	localparam logic [PW-1:0] LIM = {{(PW-1){1'b0}}, 1'b1} << (SUM_WIDTH - 1);

	logic [PW-1:0] nm_q, dm_q, ar_q, dr_q, t2_q, rm_q, rd_q, g_q;
	logic sn_q, rs_q, ovf_q, zden_q, startn_q;
	logic [SUM_WIDTH-1:0] acc_num_q;
	logic [SUM_WIDTH-2:0] acc_den_q;
	logic [SUM_WIDTH-1:0] out_num_q;
	logic [SUM_WIDTH-2:0] out_den_q;
	logic [1:0] out_stat_q;

	logic busy_q, ph_q;
	logic [2:0] op_q;
	logic [3:0] dst_q;
	logic [PW-1:0] ua_q, ub_q, uc_q;
	logic [CW-1:0] cnt_q;

	logic [IN_WIDTH-1:0] nmag_i, dmag_i;
	logic nneg_i, dneg_i;
	logic [SUM_WIDTH-1:0] acc_mag;
	logic [PW-1:0] am, ad, opa, opb, res, sum;
	logic [PW:0] rem_nx;
	logic done, sn_eff, rs_eff, fail;
	logic [SUM_WIDTH-1:0] new_num;

	assign nneg_i  = in_num[IN_WIDTH-1];
	assign dneg_i  = in_den[IN_WIDTH-1];
	assign nmag_i  = nneg_i ? (~in_num + 1'b1) : in_num;
	assign dmag_i  = dneg_i ? (~in_den + 1'b1) : in_den;
	assign acc_mag = acc_num_q[SUM_WIDTH-1] ? (~acc_num_q + 1'b1) : acc_num_q;
	assign am      = {{IN_WIDTH{1'b0}}, acc_mag};
	assign ad      = (acc_den_q == '0) ? {{(PW-1){1'b0}}, 1'b1}
	                                   : {{(IN_WIDTH+1){1'b0}}, acc_den_q};

	function automatic logic [PW-1:0] pick(input logic [3:0] code,
	                                       input logic [PW-1:0] a_m,
	                                       input logic [PW-1:0] a_d);
		logic [PW-1:0] v;
		case (code)
			fsa_pkg::R_NM: v = nm_q;
			fsa_pkg::R_DM: v = dm_q;
			fsa_pkg::R_AM: v = a_m;
			fsa_pkg::R_AD: v = a_d;
			fsa_pkg::R_AR: v = ar_q;
			fsa_pkg::R_DR: v = dr_q;
			fsa_pkg::R_RM: v = rm_q;
			fsa_pkg::R_RD: v = rd_q;
			fsa_pkg::R_G:  v = g_q;
			fsa_pkg::R_T2: v = t2_q;
			default:       v = '0;
		endcase
		return v;
	endfunction

	assign opa = pick(cmd.uop.src_a, am, ad);
	assign opb = pick(cmd.uop.src_b, am, ad);

	always_comb begin
		case (op_q)
			fsa_pkg::OP_GCD: done = ph_q && (cnt_q == '0);
			fsa_pkg::OP_DIV: done = (cnt_q == '0);
			fsa_pkg::OP_MUL: done = (ub_q == '0);
			default:         done = 1'b1;
		endcase
		done = done && busy_q;
	end

	assign res    = (op_q == fsa_pkg::OP_DIV) ? ua_q : uc_q;
	assign rem_nx = {uc_q, ua_q[PW-1]};
	assign sum    = rm_q + t2_q;
	assign sn_eff = sn_q && (nm_q != '0);

	// Final range check on the reduced value
	assign rs_eff  = rs_q && (rm_q != '0);
	assign fail    = ovf_q || ((rd_q >> (SUM_WIDTH - 1)) != '0) || (rm_q > LIM)
	                 || ((rm_q == LIM) && !rs_eff);
	assign new_num = rs_eff ? (~rm_q[SUM_WIDTH-1:0] + 1'b1) : rm_q[SUM_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			acc_num_q <= '0;
			acc_den_q <= {{(SUM_WIDTH-2){1'b0}}, 1'b1};
		end else begin
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (cmd.commit && !zden_q && !fail) begin
				acc_num_q <= new_num;
				acc_den_q <= rd_q[SUM_WIDTH-2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nm_q     <= {{SUM_WIDTH{1'b0}}, nmag_i};
			dm_q     <= {{SUM_WIDTH{1'b0}}, dmag_i};
			sn_q     <= nneg_i ^ dneg_i;
			zden_q   <= (dmag_i == '0);
			startn_q <= in_start;
			ovf_q    <= 1'b0;
		end
		if (cmd.start) begin
			op_q  <= cmd.uop.op;
			dst_q <= cmd.uop.dst;
			ph_q  <= 1'b0;
			case (cmd.uop.op)
				fsa_pkg::OP_GCD: begin
					ua_q  <= opa;
					ub_q  <= opb;
					cnt_q <= '0;
				end
				fsa_pkg::OP_DIV: begin
					ua_q  <= opa;
					ub_q  <= opb;
					uc_q  <= '0;
					cnt_q <= CW'(PW);
				end
				fsa_pkg::OP_MUL: begin
					ua_q <= opa;
					ub_q <= opb;
					uc_q <= '0;
				end
				fsa_pkg::OP_COPY: begin
					rm_q <= nm_q;
					rd_q <= dm_q;
					rs_q <= sn_q;
				end
				fsa_pkg::OP_ADD: begin
					if (acc_num_q[SUM_WIDTH-1] == sn_eff) begin
						rm_q  <= sum;
						rs_q  <= acc_num_q[SUM_WIDTH-1];
						ovf_q <= ovf_q || ((sum >> fsa_pkg::LIMIT_BITS) != '0);
					end else if (rm_q >= t2_q) begin
						rm_q <= rm_q - t2_q;
						rs_q <= acc_num_q[SUM_WIDTH-1];
					end else begin
						rm_q <= t2_q - rm_q;
						rs_q <= sn_eff;
					end
				end
				default: begin
				end
			endcase
		end else if (busy_q && !done) begin
			case (op_q)
				fsa_pkg::OP_GCD: begin
					if (ph_q) begin
						uc_q  <= uc_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end else if (ua_q == '0) begin
						uc_q <= ub_q;
						ph_q <= 1'b1;
					end else if (ub_q == '0) begin
						uc_q <= ua_q;
						ph_q <= 1'b1;
					end else if (!ua_q[0] && !ub_q[0]) begin
						ua_q  <= ua_q >> 1;
						ub_q  <= ub_q >> 1;
						cnt_q <= cnt_q + 1'b1;
					end else if (!ua_q[0]) begin
						ua_q <= ua_q >> 1;
					end else if (!ub_q[0]) begin
						ub_q <= ub_q >> 1;
					end else if (ua_q >= ub_q) begin
						ua_q <= ua_q - ub_q;
					end else begin
						ub_q <= ub_q - ua_q;
					end
				end
				fsa_pkg::OP_DIV: begin
					if (rem_nx >= {1'b0, ub_q}) begin
						uc_q <= PW'(rem_nx - {1'b0, ub_q});
						ua_q <= {ua_q[PW-2:0], 1'b1};
					end else begin
						uc_q <= rem_nx[PW-1:0];
						ua_q <= {ua_q[PW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
				end
				fsa_pkg::OP_MUL: begin
					if (ub_q[0]) begin
						uc_q <= uc_q + ua_q;
					end
					ua_q <= ua_q << 1;
					ub_q <= ub_q >> 1;
				end
				default: begin
				end
			endcase
		end
		if (done) begin
			if (op_q == fsa_pkg::OP_MUL && ((uc_q >> fsa_pkg::LIMIT_BITS) != '0)) begin
				ovf_q <= 1'b1;
			end
			case (dst_q)
				fsa_pkg::R_NM: nm_q <= res;
				fsa_pkg::R_DM: dm_q <= res;
				fsa_pkg::R_AR: ar_q <= res;
				fsa_pkg::R_DR: dr_q <= res;
				fsa_pkg::R_RM: rm_q <= res;
				fsa_pkg::R_RD: rd_q <= res;
				fsa_pkg::R_G:  g_q  <= res;
				fsa_pkg::R_T2: t2_q <= res;
				default: begin
				end
			endcase
		end
		if (cmd.commit) begin
			if (zden_q) begin
				out_num_q  <= acc_num_q;
				out_den_q  <= acc_den_q;
				out_stat_q <= fsa_pkg::STAT_ZERO_DEN;
			end else if (fail) begin
				out_num_q  <= acc_num_q;
				out_den_q  <= acc_den_q;
				out_stat_q <= fsa_pkg::STAT_OVF;
			end else begin
				out_num_q  <= new_num;
				out_den_q  <= rd_q[SUM_WIDTH-2:0];
				out_stat_q <= fsa_pkg::STAT_OK;
			end
		end
	end

	assign sts.busy      = busy_q;
	assign sts.done      = done;
	assign sts.zero_den  = zden_q;
	assign sts.start_new = startn_q;

	assign out_num    = out_num_q;
	assign out_den    = out_den_q;
	assign out_status = out_stat_q;

endmodule

/* src/fsa_ctrl.sv */
module fsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output fsa_pkg::cmd_t cmd,
	input  fsa_pkg::sts_t sts
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_ISSUE  = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [3:0] step_q;
	logic       m_tvalid_q;
	logic       slot_free;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.start  = (state_q == ST_ISSUE);
		cmd.uop    = fsa_pkg::ucode(step_q);
		cmd.commit = (state_q == ST_COMMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= fsa_pkg::STEP_FIRST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
						step_q  <= fsa_pkg::STEP_FIRST;
					end
				end
				ST_CHECK: begin
					state_q <= sts.zero_den ? ST_COMMIT : ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sts.done) begin
						if (step_q inside {fsa_pkg::STEP_LAST_ADD, fsa_pkg::STEP_COPY}) begin
							state_q <= ST_COMMIT;
						end else if (step_q == fsa_pkg::STEP_IN_DONE && sts.start_new) begin
							step_q  <= fsa_pkg::STEP_COPY;
							state_q <= ST_ISSUE;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_COMMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_issue_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.busy)
		else $error("unit started while busy");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && m_tvalid_q && !m_tready) |=> $stable(m_tvalid_q))
		else $error("pending result lost");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_CHECK))
		else $error("accepted item not processed");

endmodule

/* src/fraction_sum_accumulator_unit.sv */
// Channel  Dir  tdata (low bit up)                      tuser
// s_*      in   numerator, denominator                  start_new
// m_*      out  sum_numerator, sum_denominator          status
//
// One item is processed at a time; s_tready is high only while idle.
// A loading item runs one GCD and two divides; an adding item runs three GCDs,
// six divides, three multiplies and an add. The shared iterative unit computes
// binary GCD, one quotient bit and one multiplier bit per cycle.
// A zero denominator skips the unit and goes straight to the result.
// Reset clears the running sum to 0/1. A result waits in the output register
// while m_tready is low; the next item is still accepted meanwhile.
module fraction_sum_accumulator_unit #(
	parameter int IN_WIDTH  = 16,
	parameter int SUM_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// numerator, denominator, zero padding
	input  logic [((2*IN_WIDTH+7)/8)*8-1:0] s_tdata,
	// start_new
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// sum_numerator, sum_denominator, zero padding
	output logic [((2*SUM_WIDTH+6)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);
	localparam int OUT_W = ((2*SUM_WIDTH+6)/8)*8;

	fsa_pkg::cmd_t cmd;
	fsa_pkg::sts_t sts;
	logic [SUM_WIDTH-1:0] out_num;
	logic [SUM_WIDTH-2:0] out_den;

	// Sequence the shared arithmetic unit and own both handshakes
	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Hold the running sum, the working registers and the result register
	fsa_datapath #(
		.IN_WIDTH  (IN_WIDTH),
		.SUM_WIDTH (SUM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_num     (s_tdata[IN_WIDTH-1:0]),
		.in_den     (s_tdata[2*IN_WIDTH-1:IN_WIDTH]),
		.in_start   (s_tuser),
		.out_num    (out_num),
		.out_den    (out_den),
		.out_status (m_tuser)
	);

	assign m_tdata = OUT_W'({out_den, out_num});

endmodule

/* tb/fraction_sum_accumulator_unit_tb.sv */
module fraction_sum_accumulator_unit_tb;

	localparam int IN_W   = 16;
	localparam int SUM_W  = 32;
	localparam int SD_W   = ((2*IN_W+7)/8)*8;
	localparam int MD_W   = ((2*SUM_W+6)/8)*8;
	localparam int N_RAND = 1750;
	localparam longint CYCLE_LIMIT = 64'd4000000;

	typedef struct {
		logic signed [SUM_W-1:0] num;
		logic [SUM_W-2:0]        den;
		logic [1:0]              stat;
		logic                    known;
	} sum_result_t;

	typedef struct {
		logic signed [IN_W-1:0] num;
		logic signed [IN_W-1:0] den;
		logic                   start;
		logic                   has_exp;
		logic signed [SUM_W-1:0] e_num;
		logic [SUM_W-2:0]        e_den;
		logic [1:0]              e_stat;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SD_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MD_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	// running sum as the predictor sees it
	logic signed [SUM_W-1:0] sum_num_q;
	logic [SUM_W-2:0]        sum_den_q;

	sum_result_t expected_sums[$];
	stim_row_t   rows[$];
	int          n_mismatch = 0;
	bit          done_driving = 1'b0;
	longint      cycles = 0;

	fraction_sum_accumulator_unit #(.IN_WIDTH(IN_W), .SUM_WIDTH(SUM_W)) u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Work out the next running sum; update the predictor state on success.
	function automatic sum_result_t add_fraction(logic signed [IN_W-1:0] n,
			logic signed [IN_W-1:0] d, logic start);
		sum_result_t r;
		bit nneg, aneg, rneg;
		longint unsigned nm, dm, am, ad, g, ar, dr, t1, t2, rm, rd;
		longint unsigned lim;
		lim = 64'd1 << (SUM_W-1);
		r.known = 1'b1;
		r.num = sum_num_q;
		r.den = sum_den_q;
		r.stat = fsa_pkg::STAT_OK;
		if (d == 0) begin
			r.stat = fsa_pkg::STAT_ZERO_DEN;
			return r;
		end
		nneg = n[IN_W-1];
		nm = nneg ? longint'(-longint'(n)) : longint'(n);
		dm = d[IN_W-1] ? longint'(-longint'(d)) : longint'(d);
		if (d[IN_W-1]) nneg = !nneg;
		g = euclid(nm, dm);
		nm = nm / g;
		dm = dm / g;
		if (nm == 0) nneg = 1'b0;
		if (start) begin
			rneg = nneg;
			rm = nm;
			rd = dm;
		end else begin
			aneg = sum_num_q[SUM_W-1];
			am = aneg ? longint'(-longint'(sum_num_q)) : longint'(sum_num_q);
			ad = (sum_den_q == 0) ? 1 : sum_den_q;
			g = euclid(ad, dm);
			ar = ad / g;
			dr = dm / g;
			// operands stay below 2^32, so the products fit in 64 bits
			t1 = am * dr;
			t2 = nm * ar;
			rd = ar * dm;
			if (aneg == nneg) begin
				rm = t1 + t2;
				rneg = aneg;
			end else if (t1 >= t2) begin
				rm = t1 - t2;
				rneg = aneg;
			end else begin
				rm = t2 - t1;
				rneg = nneg;
			end
			g = euclid(rm, rd);
			rm = rm / g;
			rd = rd / g;
			if (rm == 0) rneg = 1'b0;
		end
		if (rd > lim - 1 || rm > (rneg ? lim : lim - 1)) begin
			r.stat = fsa_pkg::STAT_OVF;
			return r;
		end
		sum_num_q = rneg ? -SUM_W'(rm) : SUM_W'(rm);
		sum_den_q = rd[SUM_W-2:0];
		r.num = sum_num_q;
		r.den = sum_den_q;
		return r;
	endfunction

	function automatic void add_row(int n, int d, bit st, bit he = 0,
			longint en = 0, longint ed = 1, logic [1:0] es = fsa_pkg::STAT_OK);
		stim_row_t r;
		r.num = IN_W'(n); r.den = IN_W'(d); r.start = st; r.has_exp = he;
		r.e_num = SUM_W'(en); r.e_den = (SUM_W-1)'(ed); r.e_stat = es;
		rows.push_back(r);
	endfunction

	// Random fraction: small magnitudes mostly, extremes now and then.
	function automatic int pick_val();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 32767 : -32768;
			1, 2: return int'($urandom_range(65535)) - 32768;
			3: return 0;
			default: return int'($urandom_range(40)) - 20;
		endcase
	endfunction

	initial begin
		// directed rows: reset state, extremes, sign handling, rejection, overflow
		add_row(5, 0, 0, 1, 0, 1, fsa_pkg::STAT_ZERO_DEN);
		add_row(0, 7, 0, 1, 0, 1, fsa_pkg::STAT_OK);
		add_row(-32768, -32768, 1, 1, 1, 1, fsa_pkg::STAT_OK);
		add_row(6, -4, 1, 1, -3, 2, fsa_pkg::STAT_OK);
		add_row(1, 0, 1, 1, -3, 2, fsa_pkg::STAT_ZERO_DEN);
		add_row(32767, 1, 1, 1, 32767, 1, fsa_pkg::STAT_OK);
		add_row(-32768, 1, 1, 1, -32768, 1, fsa_pkg::STAT_OK);
		add_row(1, -32768, 1, 1, -1, 32768, fsa_pkg::STAT_OK);
		add_row(1, 32767, 0);
		add_row(1, 32765, 0);
		add_row(1, 32761, 0);
		add_row(3, 6, 1, 1, 1, 2, fsa_pkg::STAT_OK);
		add_row(-1, 2, 0, 1, 0, 1, fsa_pkg::STAT_OK);
		add_row(32767, -1, 0);
		for (int i = 0; i < 6; i++) add_row(32767, 1, 0);
		add_row(0, -1, 1, 1, 0, 1, fsa_pkg::STAT_OK);
		// large coprime denominators until the sum overflows
		add_row(1, 32749, 1);
		add_row(1, 32719, 0);
		add_row(1, 32717, 0);
		add_row(1, 32713, 0);
	end

	// drive: bursts of items with random gaps
	initial begin : drive
		stim_row_t cur;
		sum_result_t e;
		int burst, k, gap;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		sum_num_q = 0;
		sum_den_q = 1;
		burst = 0;
		for (k = 0; k < rows.size() + N_RAND; k++) begin
			if (k < rows.size()) cur = rows[k];
			else begin
				cur.num = IN_W'(pick_val());
				cur.den = IN_W'(pick_val());
				cur.start = ($urandom_range(7) == 0);
				cur.has_exp = 0;
			end
			if (burst == 0) begin
				gap = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(40));
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 12);
			end
			burst--;
			s_tvalid <= 1'b1;
			s_tdata <= SD_W'({cur.den, cur.num});
			s_tuser <= cur.start;
			do @(posedge clk); while (!s_tready);
			e = add_fraction(cur.num, cur.den, cur.start);
			if (cur.has_exp && (e.num !== cur.e_num || e.den !== cur.e_den
					|| e.stat !== cur.e_stat))
				$display("table row %0d disagrees with prediction", k);
			if (cur.has_exp) begin
				e.num = cur.e_num; e.den = cur.e_den; e.stat = cur.e_stat;
			end
			expected_sums.push_back(e);
		end
		s_tvalid <= 1'b0;
		done_driving = 1'b1;
	end

	// receiver stall pattern: alternate long ready and stalled stretches
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else if ($urandom_range(15) == 0) m_tready <= !m_tready;
		else if (cycles[12]) m_tready <= 1'b1;
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		sum_result_t e;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_sums.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				e = expected_sums.pop_front();
				if (m_tdata[SUM_W-1:0] !== e.num || m_tdata[2*SUM_W-2:SUM_W] !== e.den
						|| m_tuser !== e.stat) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("sum mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
							e.num, e.den, e.stat, $signed(m_tdata[SUM_W-1:0]),
							m_tdata[2*SUM_W-2:SUM_W], m_tuser);
				end
			end
		end
	end

	initial begin : finish_run
		wait (done_driving && expected_sums.size() == 0);
		repeat (1000) @(posedge clk);
		if (n_mismatch == 0 && expected_sums.size() == 0)
			$display("[fraction_sum_accumulator_unit] OK");
		else
			$display("[fraction_sum_accumulator_unit] ERROR");
		$finish;
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("[fraction_sum_accumulator_unit] ERROR");
		$finish;
	end

endmodule
